// ===== design/kcl_pkg.sv =====
// Shared types and constants for the keypad code lock sequencer.
package kcl_pkg;

  localparam int unsigned KeyW  = 8;
  localparam int unsigned PhW   = 4;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CODE_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CODE_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CODE_THIRD  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WAIT_LIMIT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_LIMIT  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [KeyW-1:0] RST_CODE_FIRST  = 8'd49;
  localparam logic [KeyW-1:0] RST_CODE_SECOND = 8'd50;
  localparam logic [KeyW-1:0] RST_CODE_THIRD  = 8'd51;
  localparam logic [KeyW-1:0] RST_WAIT_LIMIT  = 8'd30;
  localparam logic [KeyW-1:0] RST_HOLD_LIMIT  = 8'd200;

  // Menu keys
  localparam logic [KeyW-1:0] KEY_A = 8'h41;
  localparam logic [KeyW-1:0] KEY_B = 8'h42;
  localparam logic [KeyW-1:0] KEY_C = 8'h43;

  // Phase codes seen on the result channel
  localparam logic [PhW-1:0] PHASE_COMPARE = 4'd10;
  localparam logic [PhW-1:0] PHASE_GRANTED = 4'd11;

  typedef struct packed {
    logic            motion_seen;
    logic [KeyW-1:0] pad_key;
    logic            remote_valid;
    logic [KeyW-1:0] remote_byte;
  } in_item_t;

  typedef struct packed {
    logic [PhW-1:0]  phase;
    logic            granted;
    logic            locked_out;
    logic            by_remote;
    logic [KeyW-1:0] entry_first;
    logic [KeyW-1:0] entry_second;
    logic [KeyW-1:0] entry_third;
  } out_item_t;

  typedef struct packed {
    logic [KeyW-1:0] code_first;
    logic [KeyW-1:0] code_second;
    logic [KeyW-1:0] code_third;
    logic [KeyW-1:0] wait_limit;
    logic [KeyW-1:0] hold_limit;
  } cfg_t;

endpackage

// ===== design/kcl_if.sv =====
// Valid/ready channel interfaces for input ticks, results and configuration writes.
interface kcl_in_if;
  logic       valid;
  logic       ready;
  logic       motion_seen;
  logic [7:0] pad_key;
  logic       remote_valid;
  logic [7:0] remote_byte;

  modport source (output valid, motion_seen, pad_key, remote_valid, remote_byte,
                  input ready);
  modport sink   (input valid, motion_seen, pad_key, remote_valid, remote_byte,
                  output ready);
endinterface

interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] phase;
  logic       granted;
  logic       locked_out;
  logic       by_remote;
  logic [7:0] entry_first;
  logic [7:0] entry_second;
  logic [7:0] entry_third;

  modport source (output valid, phase, granted, locked_out, by_remote,
                  entry_first, entry_second, entry_third, input ready);
  modport sink   (input valid, phase, granted, locked_out, by_remote,
                  entry_first, entry_second, entry_third, output ready);
endinterface

interface kcl_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/keypad_code_lock_sequencer_unit.sv =====
// Keypad code lock sequencer: input register, lock state machine and result register.
// Path: an accepted tick waits in the input register; the state machine computes its
// result, which the result register loads once the output is free.
// Throughput: one tick per cycle while results are taken, with the state update
// between the input register and the result register; the input stalls only while the
// input register is full and a waiting result is not taken.
// Reset: asynchronous, active low; phase idle, counters, flags and entries
// cleared, configuration registers to their default code and limits.
module keypad_code_lock_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  kcl_in_if.sink     in_i,
  kcl_out_if.source  out_o,
  kcl_cfg_if.sink    cfg_i
);
  import kcl_pkg::*;

  cfg_t      cfg;
  in_item_t  stg_q;
  logic      stg_valid_q;
  out_item_t res;
  out_item_t out_q;
  logic      out_valid_q;
  logic      adv;
  logic      in_acc;

  assign adv        = stg_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !stg_valid_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  kcl_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  kcl_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (stg_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_q.motion_seen  <= in_i.motion_seen;
      stg_q.pad_key      <= in_i.pad_key;
      stg_q.remote_valid <= in_i.remote_valid;
      stg_q.remote_byte  <= in_i.remote_byte;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.phase        = out_q.phase;
  assign out_o.granted      = out_q.granted;
  assign out_o.locked_out   = out_q.locked_out;
  assign out_o.by_remote    = out_q.by_remote;
  assign out_o.entry_first  = out_q.entry_first;
  assign out_o.entry_second = out_q.entry_second;
  assign out_o.entry_third  = out_q.entry_third;

`ifndef SYNTH
  // a new transaction into a full input register must drain it the same cycle
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && stg_valid_q) |-> adv)
    else $error("input register overrun");
  // every advance produces a visible result
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advance without result");
  // lockout and grant only show up with their own phase
  a_flag_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.locked_out || out_q.phase == PHASE_COMPARE) &&
                    (out_q.granted == (out_q.phase == PHASE_GRANTED)))
    else $error("result flags disagree with phase");
`endif

endmodule

// ===== design/kcl_cfg_regs.sv =====
// Configuration register file: code characters and timer limits.
module kcl_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  kcl_cfg_if.sink       cfg_i,
  output kcl_pkg::cfg_t cfg_o
);
  import kcl_pkg::*;

  cfg_t regs_q;
  logic wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid;
  assign cfg_o = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.code_first  <= RST_CODE_FIRST;
      regs_q.code_second <= RST_CODE_SECOND;
      regs_q.code_third  <= RST_CODE_THIRD;
      regs_q.wait_limit  <= RST_WAIT_LIMIT;
      regs_q.hold_limit  <= RST_HOLD_LIMIT;
    end else if (wr) begin
      unique case (cfg_i.index)
        CFG_CODE_FIRST:  regs_q.code_first  <= cfg_i.data;
        CFG_CODE_SECOND: regs_q.code_second <= cfg_i.data;
        CFG_CODE_THIRD:  regs_q.code_third  <= cfg_i.data;
        CFG_WAIT_LIMIT:  regs_q.wait_limit  <= cfg_i.data;
        CFG_HOLD_LIMIT:  regs_q.hold_limit  <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/kcl_fsm.sv =====
// Lock sequence state machine: one state update and one result per tick.
module kcl_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  kcl_pkg::in_item_t  item_i,
  input  kcl_pkg::cfg_t      cfg_i,
  output kcl_pkg::out_item_t res_o
);
  import kcl_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_MENU    = 4'd1,
    PH_WAIT1   = 4'd2,
    PH_CAP1    = 4'd3,
    PH_SHOW    = 4'd4,
    PH_CHANGE  = 4'd5,
    PH_WAIT2   = 4'd6,
    PH_CAP2    = 4'd7,
    PH_WAIT3   = 4'd8,
    PH_CAP3    = 4'd9,
    PH_COMPARE = 4'd10,
    PH_GRANTED = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    MENU_NONE   = 2'd0,
    MENU_ENTER  = 2'd1,
    MENU_CHANGE = 2'd2,
    MENU_SHOW   = 2'd3
  } menu_e;

  phase_e          phase_q, phase_d;
  logic [KeyW-1:0] tick_q, tick_d;
  menu_e           menu_q, menu_d;
  logic [KeyW-1:0] keys_q [3];
  logic [KeyW-1:0] keys_d [3];
  logic [2:0]      pres_q, pres_d;
  logic            rem_q, rem_d;
  logic            grant_q, grant_d;

  logic            expired;
  logic [KeyW-1:0] limit;
  logic            match;
  logic [1:0]      slot;
  logic            cap_pres;

  assign match = (keys_q[0] == cfg_i.code_first) && (keys_q[1] == cfg_i.code_second) &&
                 (keys_q[2] == cfg_i.code_third);

  assign limit   = (phase_q == PH_GRANTED) ? cfg_i.hold_limit : cfg_i.wait_limit;
  assign expired = tick_q > limit;

  always_comb begin
    unique case (phase_q)
      PH_CAP2: slot = 2'd1;
      PH_CAP3: slot = 2'd2;
      default: slot = 2'd0;
    endcase
  end
  assign cap_pres = pres_q[slot];

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    menu_d  = menu_q;
    keys_d  = keys_q;
    pres_d  = pres_q;
    rem_d   = rem_q;
    grant_d = grant_q;

    // transition
    unique case (phase_q)
      PH_IDLE: if (item_i.motion_seen) phase_d = PH_MENU;
      PH_MENU: begin
        unique case (menu_q)
          MENU_ENTER:  phase_d = PH_WAIT1;
          MENU_CHANGE: phase_d = PH_CHANGE;
          MENU_SHOW:   phase_d = PH_SHOW;
          default:     phase_d = PH_MENU;
        endcase
      end
      PH_WAIT1, PH_SHOW, PH_CHANGE, PH_WAIT2, PH_WAIT3, PH_GRANTED: begin
        if (expired) begin
          tick_d = '0;
          unique case (phase_q)
            PH_WAIT1:   phase_d = PH_CAP1;
            PH_WAIT2:   phase_d = PH_CAP2;
            PH_WAIT3:   phase_d = PH_CAP3;
            PH_GRANTED: begin
              phase_d = PH_IDLE;
              grant_d = 1'b0;
            end
            default:    phase_d = PH_MENU;
          endcase
        end else begin
          tick_d = 8'(tick_q + 8'd1);
        end
      end
      PH_CAP1, PH_CAP2, PH_CAP3: begin
        priority if (cap_pres && !rem_q) begin
          unique case (phase_q)
            PH_CAP1: phase_d = PH_WAIT2;
            PH_CAP2: phase_d = PH_WAIT3;
            default: phase_d = PH_COMPARE;
          endcase
        end else if (!cap_pres && rem_q) begin
          grant_d = 1'b1;
          phase_d = PH_GRANTED;
        end else begin
          phase_d = phase_q;
        end
      end
      PH_COMPARE: begin
        if (grant_q) begin
          phase_d = PH_GRANTED;
          tick_d  = '0;
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    // action of the new state
    unique case (phase_d)
      PH_MENU: begin
        priority if (item_i.pad_key == KEY_A) menu_d = MENU_ENTER;
        else if (item_i.pad_key == KEY_B) menu_d = MENU_CHANGE;
        else if (item_i.pad_key == KEY_C) menu_d = MENU_SHOW;
        else menu_d = MENU_NONE;
      end
      PH_CAP1, PH_CAP2, PH_CAP3: begin
        if (item_i.remote_valid) begin
          rem_d = 1'b1;
          unique case (phase_d)
            PH_CAP1: keys_d[0] = item_i.remote_byte;
            PH_CAP2: keys_d[1] = item_i.remote_byte;
            default: keys_d[2] = item_i.remote_byte;
          endcase
        end else begin
          unique case (phase_d)
            PH_CAP1: begin
              rem_d     = 1'b0;
              keys_d[0] = item_i.pad_key;
              pres_d[0] = item_i.pad_key != '0;
            end
            PH_CAP2: begin
              keys_d[1] = item_i.pad_key;
              pres_d[1] = item_i.pad_key != '0;
            end
            default: begin
              keys_d[2] = item_i.pad_key;
              pres_d[2] = item_i.pad_key != '0;
            end
          endcase
        end
      end
      PH_COMPARE: if (match) grant_d = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res_o.phase        = phase_d;
    res_o.granted      = phase_d == PH_GRANTED;
    res_o.locked_out   = (phase_d == PH_COMPARE) && !match;
    res_o.by_remote    = rem_d;
    res_o.entry_first  = keys_d[0];
    res_o.entry_second = keys_d[1];
    res_o.entry_third  = keys_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      menu_q  <= MENU_NONE;
      keys_q  <= '{default: '0};
      pres_q  <= '0;
      rem_q   <= 1'b0;
      grant_q <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      menu_q  <= menu_d;
      keys_q  <= keys_d;
      pres_q  <= pres_d;
      rem_q   <= rem_d;
      grant_q <= grant_d;
    end
  end

`ifndef SYNTH
  // a lockout result never coexists with a pending grant
  a_lock_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && res_o.locked_out) |-> !grant_d)
    else $error("lockout reported with grant pending");
  // state only moves on an advance
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(phase_q) && $stable(tick_q))
    else $error("state moved without a transaction");
  // grant flag is always clear in idle
  a_idle_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> !grant_q)
    else $error("grant flag set in idle");
`endif

endmodule

// ===== tb/tb_keypad_code_lock_sequencer_unit.sv =====
// Testbench for the keypad code lock sequencer: random and directed ticks checked against a predictor.
module tb_keypad_code_lock_sequencer_unit;
  import kcl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_MENU    = 4'd1,
    ST_WAIT1   = 4'd2,
    ST_CAP1    = 4'd3,
    ST_SHOW    = 4'd4,
    ST_CHANGE  = 4'd5,
    ST_WAIT2   = 4'd6,
    ST_CAP2    = 4'd7,
    ST_WAIT3   = 4'd8,
    ST_CAP3    = 4'd9,
    ST_COMPARE = 4'd10,
    ST_GRANTED = 4'd11
  } lock_phase_e;

  typedef enum logic [1:0] {NO_CHOICE, PICK_ENTRY, PICK_CHANGE, PICK_SHOW} menu_pick_e;

  localparam logic [KeyW-1:0] NO_KEY     = 8'h00;
  localparam logic [KeyW-1:0] DIGIT_ZERO = 8'h30;
  localparam int unsigned     FEED_BOUND = 3000;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  kcl_in_if  tick_if ();
  kcl_out_if status_if ();
  kcl_cfg_if reg_if ();

  keypad_code_lock_sequencer_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (status_if),
    .cfg_i  (reg_if)
  );

  // Predicted lock state and configuration
  lock_phase_e     lock_phase;
  logic [KeyW-1:0] lock_ticks;
  menu_pick_e      lock_choice;
  logic [KeyW-1:0] lock_keys [3];
  logic            lock_present [3];
  logic            lock_remote;
  logic            lock_grant;
  cfg_t            lock_cfg;

  out_item_t   status_q [$];
  int unsigned fail_count  = 0;
  bit          gaps_on     = 1'b1;
  bit          stalls_on   = 1'b1;
  int unsigned holdoff_req = 0;

  function automatic void lock_reset();
    lock_phase  = ST_IDLE;
    lock_ticks  = '0;
    lock_choice = NO_CHOICE;
    for (int i = 0; i < 3; i++) begin
      lock_keys[i]    = '0;
      lock_present[i] = 1'b0;
    end
    lock_remote = 1'b0;
    lock_grant  = 1'b0;
    lock_cfg.code_first  = RST_CODE_FIRST;
    lock_cfg.code_second = RST_CODE_SECOND;
    lock_cfg.code_third  = RST_CODE_THIRD;
    lock_cfg.wait_limit  = RST_WAIT_LIMIT;
    lock_cfg.hold_limit  = RST_HOLD_LIMIT;
  endfunction

  function automatic logic [KeyW-1:0] code_of(int slot);
    case (slot)
      0:       return lock_cfg.code_first;
      1:       return lock_cfg.code_second;
      default: return lock_cfg.code_third;
    endcase
  endfunction

  function automatic bit code_ok();
    return lock_keys[0] == lock_cfg.code_first && lock_keys[1] == lock_cfg.code_second &&
           lock_keys[2] == lock_cfg.code_third;
  endfunction

  function automatic lock_phase_e timer_step(lock_phase_e here, lock_phase_e ahead,
                                             logic [KeyW-1:0] limit);
    if (lock_ticks > limit) begin
      lock_ticks = '0;
      return ahead;
    end
    lock_ticks = lock_ticks + 8'd1;
    return here;
  endfunction

  function automatic lock_phase_e capture_exit(int slot, lock_phase_e here, lock_phase_e ahead);
    if (lock_present[slot] && !lock_remote) return ahead;
    if (!lock_present[slot] && lock_remote) begin
      lock_grant = 1'b1;
      return ST_GRANTED;
    end
    return here;
  endfunction

  function automatic void store_capture(int slot, in_item_t t);
    if (t.remote_valid) begin
      lock_remote     = 1'b1;
      lock_keys[slot] = t.remote_byte;
    end else begin
      // only the first capture drops an earlier remote entry
      if (slot == 0) lock_remote = 1'b0;
      lock_keys[slot]    = t.pad_key;
      lock_present[slot] = (t.pad_key != NO_KEY);
    end
  endfunction

  // Take the transition, then run the new state's action with this tick's inputs
  function automatic out_item_t advance_lock(in_item_t t);
    lock_phase_e p;
    out_item_t   r;
    p = lock_phase;
    case (lock_phase)
      ST_IDLE:    if (t.motion_seen) p = ST_MENU;
      ST_MENU: begin
        case (lock_choice)
          PICK_ENTRY:  p = ST_WAIT1;
          PICK_CHANGE: p = ST_CHANGE;
          PICK_SHOW:   p = ST_SHOW;
          default:     p = ST_MENU;
        endcase
      end
      ST_WAIT1:   p = timer_step(ST_WAIT1, ST_CAP1, lock_cfg.wait_limit);
      ST_CAP1:    p = capture_exit(0, ST_CAP1, ST_WAIT2);
      ST_SHOW:    p = timer_step(ST_SHOW, ST_MENU, lock_cfg.wait_limit);
      ST_CHANGE:  p = timer_step(ST_CHANGE, ST_MENU, lock_cfg.wait_limit);
      ST_WAIT2:   p = timer_step(ST_WAIT2, ST_CAP2, lock_cfg.wait_limit);
      ST_CAP2:    p = capture_exit(1, ST_CAP2, ST_WAIT3);
      ST_WAIT3:   p = timer_step(ST_WAIT3, ST_CAP3, lock_cfg.wait_limit);
      ST_CAP3:    p = capture_exit(2, ST_CAP3, ST_COMPARE);
      ST_COMPARE: begin
        if (lock_grant) begin
          p          = ST_GRANTED;
          lock_ticks = '0;
        end
      end
      ST_GRANTED: begin
        p = timer_step(ST_GRANTED, ST_IDLE, lock_cfg.hold_limit);
        if (p == ST_IDLE) lock_grant = 1'b0;
      end
      default:    p = ST_IDLE;
    endcase
    lock_phase = p;

    case (p)
      ST_MENU: begin
        if (t.pad_key == KEY_A) lock_choice = PICK_ENTRY;
        else if (t.pad_key == KEY_B) lock_choice = PICK_CHANGE;
        else if (t.pad_key == KEY_C) lock_choice = PICK_SHOW;
        else lock_choice = NO_CHOICE;
      end
      ST_CAP1:    store_capture(0, t);
      ST_CAP2:    store_capture(1, t);
      ST_CAP3:    store_capture(2, t);
      ST_COMPARE: if (code_ok()) lock_grant = 1'b1;
      default: ;
    endcase

    r.phase        = p;
    r.granted      = (p == ST_GRANTED);
    r.locked_out   = (p == ST_COMPARE) && !code_ok();
    r.by_remote    = lock_remote;
    r.entry_first  = lock_keys[0];
    r.entry_second = lock_keys[1];
    r.entry_third  = lock_keys[2];
    return r;
  endfunction

  function automatic bit locked();
    return lock_phase == ST_COMPARE && !lock_grant;
  endfunction

  function automatic in_item_t tick_of(logic m, logic [KeyW-1:0] k, logic rv,
                                       logic [KeyW-1:0] rb);
    in_item_t t;
    t.motion_seen  = m;
    t.pad_key      = k;
    t.remote_valid = rv;
    t.remote_byte  = rb;
    return t;
  endfunction

  // Mostly well-formed sessions: menu keys where the menu is next, code keys before captures
  function automatic in_item_t pick_tick();
    in_item_t    t;
    int unsigned r;
    int          slot;
    t.motion_seen  = 1'($urandom_range(0, 1));
    t.pad_key      = KeyW'($urandom_range(0, 255));
    t.remote_valid = ($urandom_range(0, 7) == 0);
    t.remote_byte  = KeyW'($urandom_range(0, 255));
    r    = $urandom_range(0, 19);
    slot = -1;
    case (lock_phase)
      ST_IDLE, ST_MENU, ST_SHOW, ST_CHANGE: begin
        if (lock_phase == ST_IDLE) t.motion_seen = ($urandom_range(0, 3) != 0);
        if (r < 10) t.pad_key = KEY_A;
        else if (r < 12) t.pad_key = KEY_B;
        else if (r < 14) t.pad_key = KEY_C;
      end
      ST_WAIT1, ST_CAP1: slot = 0;
      ST_WAIT2, ST_CAP2: slot = 1;
      ST_WAIT3, ST_CAP3: slot = 2;
      default: ;
    endcase
    if (slot >= 0) begin
      if (r < 13) begin
        t.pad_key      = code_of(slot);
        t.remote_valid = 1'b0;
      end else if (r < 15) begin
        t.pad_key      = NO_KEY;
        t.remote_valid = 1'b0;
      end else if (r < 17) begin
        t.remote_valid = 1'b1;
      end else if (r < 18) begin
        t.remote_valid = 1'b0;
      end
    end
    return t;
  endfunction

  function automatic logic [KeyW-1:0] random_code();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return NO_KEY;
    if (r < 9) return KeyW'(DIGIT_ZERO + $urandom_range(0, 9));
    return KeyW'($urandom_range(1, 255));
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.code_first  = random_code();
    c.code_second = random_code();
    c.code_third  = random_code();
    c.wait_limit  = KeyW'($urandom_range(0, 4));
    c.hold_limit  = KeyW'($urandom_range(0, 12));
    return c;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic void check_field(string name, logic [KeyW-1:0] want, logic [KeyW-1:0] got);
    if (want !== got) note_failure($sformatf("%s: expected %0h, got %0h", name, want, got));
  endfunction

  // Result side: random stalls, plus a long hold-off when a test asks for one
  initial begin
    int unsigned stall_left;
    stall_left      = 0;
    status_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req > 0) begin
        status_if.ready <= 1'b0;
        holdoff_req--;
      end else if (stall_left > 0) begin
        status_if.ready <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        status_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        status_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && status_if.valid && status_if.ready) begin
      got.phase        = status_if.phase;
      got.granted      = status_if.granted;
      got.locked_out   = status_if.locked_out;
      got.by_remote    = status_if.by_remote;
      got.entry_first  = status_if.entry_first;
      got.entry_second = status_if.entry_second;
      got.entry_third  = status_if.entry_third;
      if (status_q.size() == 0) begin
        note_failure($sformatf("unexpected status transaction, phase %0d", got.phase));
      end else begin
        want = status_q.pop_front();
        check_field("phase", KeyW'(want.phase), KeyW'(got.phase));
        check_field("granted", KeyW'(want.granted), KeyW'(got.granted));
        check_field("locked_out", KeyW'(want.locked_out), KeyW'(got.locked_out));
        check_field("by_remote", KeyW'(want.by_remote), KeyW'(got.by_remote));
        check_field("entry_first", want.entry_first, got.entry_first);
        check_field("entry_second", want.entry_second, got.entry_second);
        check_field("entry_third", want.entry_third, got.entry_third);
      end
    end
  end

  task automatic send_tick(in_item_t t);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    tick_if.valid        <= 1'b1;
    tick_if.motion_seen  <= t.motion_seen;
    tick_if.pad_key      <= t.pad_key;
    tick_if.remote_valid <= t.remote_valid;
    tick_if.remote_byte  <= t.remote_byte;
    do @(posedge clk_i); while (!tick_if.ready);
    status_q.push_back(advance_lock(t));
  endtask

  task automatic wait_drained();
    if (tick_if.valid) tick_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [KeyW-1:0] v);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= v;
    do @(posedge clk_i); while (!reg_if.ready);
    case (idx)
      CFG_CODE_FIRST:  lock_cfg.code_first  = v;
      CFG_CODE_SECOND: lock_cfg.code_second = v;
      CFG_CODE_THIRD:  lock_cfg.code_third  = v;
      CFG_WAIT_LIMIT:  lock_cfg.wait_limit  = v;
      CFG_HOLD_LIMIT:  lock_cfg.hold_limit  = v;
      default: ;
    endcase
  endtask

  task automatic apply_config(cfg_t c);
    wait_drained();
    write_reg(CFG_CODE_FIRST, c.code_first);
    write_reg(CFG_CODE_SECOND, c.code_second);
    write_reg(CFG_CODE_THIRD, c.code_third);
    write_reg(CFG_WAIT_LIMIT, c.wait_limit);
    write_reg(CFG_HOLD_LIMIT, c.hold_limit);
    reg_if.valid <= 1'b0;
  endtask

  // A lockout only ends when the code is rewritten to match the entries
  task automatic unlock_code();
    cfg_t c;
    c             = lock_cfg;
    c.code_first  = lock_keys[0];
    c.code_second = lock_keys[1];
    c.code_third  = lock_keys[2];
    apply_config(c);
  endtask

  task automatic feed_until(lock_phase_e target, in_item_t t);
    int unsigned n;
    n = 0;
    while (lock_phase != target && n < FEED_BOUND) begin
      send_tick(t);
      n++;
    end
  endtask

  task automatic random_ticks(int unsigned count);
    repeat (count) begin
      if (locked()) unlock_code();
      send_tick(pick_tick());
    end
  endtask

  task automatic settle_idle();
    in_item_t    t;
    int unsigned n;
    n = 0;
    while (lock_phase != ST_IDLE && n < FEED_BOUND) begin
      if (locked()) unlock_code();
      t             = pick_tick();
      t.motion_seen = 1'b0;
      send_tick(t);
      n++;
    end
  endtask

  task automatic test_menu_choices();
    // shorten the timers, leave the code at its reset value
    write_reg(CFG_WAIT_LIMIT, 8'd0);
    write_reg(CFG_HOLD_LIMIT, 8'd1);
    reg_if.valid <= 1'b0;
    send_tick(tick_of(1'b0, 8'hFF, 1'b1, 8'hFF));
    send_tick(tick_of(1'b0, NO_KEY, 1'b0, 8'h00));
    send_tick(tick_of(1'b1, NO_KEY, 1'b0, 8'h00));
    send_tick(tick_of(1'b1, KEY_B, 1'b0, 8'h00));
    send_tick(tick_of(1'b0, KEY_C, 1'b1, 8'h5A));
    feed_until(ST_MENU, tick_of(1'b0, KEY_C, 1'b0, 8'h00));
    send_tick(tick_of(1'b0, NO_KEY, 1'b0, 8'h00));
    feed_until(ST_MENU, tick_of(1'b1, KEY_A, 1'b1, 8'h00));
  endtask

  task automatic test_code_entry();
    feed_until(ST_CAP1, tick_of(1'b0, RST_CODE_FIRST, 1'b0, 8'h00));
    feed_until(ST_CAP2, tick_of(1'b0, RST_CODE_SECOND, 1'b0, 8'h00));
    feed_until(ST_COMPARE, tick_of(1'b0, RST_CODE_THIRD, 1'b0, 8'h00));
    feed_until(ST_IDLE, tick_of(1'b0, NO_KEY, 1'b1, 8'hC3));
  endtask

  task automatic test_remote_entry();
    // remote byte at the first capture, with no key flagged there, leads to a grant
    feed_until(ST_MENU, tick_of(1'b1, KEY_A, 1'b0, 8'h00));
    feed_until(ST_CAP1, tick_of(1'b0, NO_KEY, 1'b0, 8'h00));
    send_tick(tick_of(1'b0, NO_KEY, 1'b1, 8'hFF));
    feed_until(ST_IDLE, tick_of(1'b0, 8'hFF, 1'b0, 8'h00));
    // remote at the second capture meets a stale key flag and holds until a no-key tick
    feed_until(ST_MENU, tick_of(1'b1, KEY_A, 1'b0, 8'h00));
    feed_until(ST_CAP1, tick_of(1'b0, RST_CODE_FIRST, 1'b0, 8'h00));
    feed_until(ST_CAP2, tick_of(1'b0, NO_KEY, 1'b1, 8'h00));
    send_tick(tick_of(1'b0, 8'h7F, 1'b1, 8'h80));
    send_tick(tick_of(1'b0, NO_KEY, 1'b0, 8'h00));
    feed_until(ST_IDLE, tick_of(1'b0, NO_KEY, 1'b0, 8'h00));
  endtask

  task automatic test_lockout();
    feed_until(ST_MENU, tick_of(1'b1, KEY_A, 1'b0, 8'h00));
    feed_until(ST_CAP1, tick_of(1'b0, 8'hFF, 1'b0, 8'h00));
    feed_until(ST_CAP2, tick_of(1'b0, 8'h80, 1'b0, 8'h00));
    feed_until(ST_COMPARE, tick_of(1'b0, 8'h7F, 1'b0, 8'h00));
    repeat (3) send_tick(tick_of(1'b1, KEY_A, 1'b1, RST_CODE_FIRST));
    unlock_code();
    feed_until(ST_IDLE, tick_of(1'b0, NO_KEY, 1'b0, 8'h00));
  endtask

  task automatic test_backpressure();
    gaps_on     = 1'b0;
    holdoff_req = 60;
    random_ticks(40);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    for (int ph = 0; ph < 5; ph++) begin
      c = random_config();
      if (ph == 0) begin
        c.wait_limit = 8'd0;
        c.hold_limit = 8'd0;
      end
      apply_config(c);
      gaps_on   = (ph != 2);
      stalls_on = (ph != 3);
      random_ticks(40);
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_timer_extremes();
    cfg_t c;
    settle_idle();
    c            = lock_cfg;
    c.wait_limit = 8'd254;
    apply_config(c);
    feed_until(ST_MENU, tick_of(1'b1, KEY_C, 1'b0, 8'h00));
    feed_until(ST_SHOW, tick_of(1'b0, NO_KEY, 1'b0, 8'h00));
    feed_until(ST_MENU, tick_of(1'b0, KEY_A, 1'b0, 8'h00));
    c.wait_limit = 8'd0;
    apply_config(c);
    feed_until(ST_CAP1, tick_of(1'b0, NO_KEY, 1'b0, 8'h00));
    send_tick(tick_of(1'b0, NO_KEY, 1'b1, 8'hA5));
    feed_until(ST_IDLE, tick_of(1'b0, NO_KEY, 1'b0, 8'h00));
  endtask

  task automatic test_steady_stream();
    apply_config(random_config());
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_ticks(60);
  endtask

  initial begin
    rst_ni               = 1'b0;
    tick_if.valid        = 1'b0;
    tick_if.motion_seen  = 1'b0;
    tick_if.pad_key      = '0;
    tick_if.remote_valid = 1'b0;
    tick_if.remote_byte  = '0;
    reg_if.valid         = 1'b0;
    reg_if.index         = '0;
    reg_if.data          = '0;
    lock_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_menu_choices();
    test_code_entry();
    test_remote_entry();
    test_lockout();
    test_backpressure();
    test_random_traffic();
    test_timer_extremes();
    test_steady_stream();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && status_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/kcl_pkg.sv
design/kcl_if.sv
design/kcl_cfg_regs.sv
design/kcl_fsm.sv
design/keypad_code_lock_sequencer_unit.sv
tb/tb_keypad_code_lock_sequencer_unit.sv
